// ===== rtl/sdreg_pkg.sv =====
// Package for the SD card CID/CSD register decoder.
// Holds the shared constants, register index codes and record types.
// Depends on nothing; the capacity module, the decoder top level and the testbench import it.
package sdreg_pkg;

   localparam logic [7:0]  START_TOKEN     = 8'hFE;
   localparam logic [14:0] TIMEOUT_RESET   = 15'd20000;
   localparam int          REG_BLOCK_BYTES = 18;
   localparam logic [4:0]  LAST_BYTE_IDX   = 5'(REG_BLOCK_BYTES - 1);
   localparam logic [4:0]  CID_HI_BYTES    = 5'd8;
   localparam logic [4:0]  CID_END_IDX     = 5'd15;
   localparam int          SECTOR_SHIFT    = 19;

   localparam logic [4:0] CSD_IDX_BL_LEN   = 5'd5;
   localparam logic [4:0] CSD_IDX_SIZE_A   = 5'd6;
   localparam logic [4:0] CSD_IDX_SIZE_B   = 5'd7;
   localparam logic [4:0] CSD_IDX_SIZE_C   = 5'd8;
   localparam logic [4:0] CSD_IDX_MULT_A   = 5'd9;
   localparam logic [4:0] CSD_IDX_MULT_B   = 5'd10;
   localparam logic [4:0] CSD_IDX_MISC     = 5'd14;

   typedef enum logic {
      CSR_CARD_IS_V2    = 1'b0,
      CSR_START_TIMEOUT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic        v2;
      logic [21:0] size_count;
      logic [3:0]  block_len;
      logic [2:0]  multiplier;
   } csd_state_type;

   typedef struct packed {
      logic        status;
      logic        which_reg;
      logic [7:0]  manufacturer;
      logic [15:0] oem_id;
      logic [39:0] product_name;
      logic [7:0]  revision;
      logic [31:0] serial_number;
      logic [15:0] mfg_date;
      logic [41:0] capacity_bytes;
      logic [2:0]  csd_flags;
      logic [1:0]  file_format;
   } rsp_payload_type;

endpackage

// ===== rtl/sdreg_req_if.sv =====
// Input channel of the SD card register decoder: one received byte per item.
// Valid/ready handshake; no dependencies.
interface sdreg_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       reg_kind;

   modport source (output valid, output rx_byte, output reg_kind, input ready);
   modport sink (input valid, input rx_byte, input reg_kind, output ready);
endinterface

// ===== rtl/sdreg_rsp_if.sv =====
// Result channel of the SD card register decoder: one decoded register per item.
// Valid/ready handshake; no dependencies.
interface sdreg_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic        which_reg;
   logic [7:0]  manufacturer;
   logic [15:0] oem_id;
   logic [39:0] product_name;
   logic [7:0]  revision;
   logic [31:0] serial_number;
   logic [15:0] mfg_date;
   logic [41:0] capacity_bytes;
   logic [2:0]  csd_flags;
   logic [1:0]  file_format;

   modport source (output valid, output status, output which_reg, output manufacturer,
                   output oem_id, output product_name, output revision,
                   output serial_number, output mfg_date, output capacity_bytes,
                   output csd_flags, output file_format, input ready);
   modport sink (input valid, input status, input which_reg, input manufacturer,
                 input oem_id, input product_name, input revision,
                 input serial_number, input mfg_date, input capacity_bytes,
                 input csd_flags, input file_format, output ready);
endinterface

// ===== rtl/sdreg_capacity.sv =====
// Card capacity in bytes from the captured CSD size fields.
// Uses the record types of sdreg_pkg.
module sdreg_capacity
   import sdreg_pkg::*;
(
   input  csd_state_type csd,
   output logic [41:0]   capacity_bytes
);

   logic [22:0] v2_count;
   logic [12:0] v1_count;
   logic [4:0]  v1_shift;
   logic [31:0] v1_bytes;

   always_comb begin
      v2_count = {1'b0, csd.size_count} + 23'd1;
      v1_count = {1'b0, csd.size_count[11:0]} + 13'd1;
      v1_shift = {2'b00, csd.multiplier} + {1'b0, csd.block_len} + 5'd2;
      v1_bytes = {19'd0, v1_count} << v1_shift;
      if (csd.v2) begin
         capacity_bytes = {v2_count, {SECTOR_SHIFT{1'b0}}};
      end else begin
         capacity_bytes = {10'd0, v1_bytes};
      end
   end

endmodule

// ===== rtl/sd_cid_csd_register_decoder_top.sv =====
// SD card CID/CSD register decoder, top level.
// Uses sdreg_pkg, the sdreg_req_if and sdreg_rsp_if channels and sdreg_capacity.
//
// The block takes one received SPI byte per cycle, hunts for the start token,
// collects the 18-byte register block and presents the decoded CID or CSD
// fields in the cycle after the last byte is taken. A token that does not come
// within start_timeout - 1 bytes yields a result with status set. Every byte is
// processed in the cycle it is taken, so the sustained rate is one byte per
// clock; the input is held off only while a finished result waits in the
// output register and the result side is not ready.
module sd_cid_csd_register_decoder_top
   import sdreg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [14:0] csr_wdata,
   sdreg_req_if.sink   req_ch,
   sdreg_rsp_if.source rsp_ch
);

   logic            card_is_v2_ff, card_is_v2_in;
   logic [14:0]     start_timeout_ff, start_timeout_in;
   logic            in_block_ff, in_block_in;
   logic [4:0]      byte_idx_ff, byte_idx_in;
   logic [14:0]     timeout_left_ff, timeout_left_in;
   logic [63:0]     cid_hi_ff, cid_hi_in;
   logic [55:0]     cid_lo_ff, cid_lo_in;
   logic [21:0]     csd_size_ff, csd_size_in;
   logic [3:0]      csd_bl_ff, csd_bl_in;
   logic [2:0]      csd_mult_ff, csd_mult_in;
   logic [4:0]      csd_misc_ff, csd_misc_in;
   logic            kind_ff, kind_in;
   logic            v2_ff, v2_in;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_ff, out_in;

   logic            accept;
   logic            load;
   logic [14:0]     timeout_dec;
   csd_state_type   csd_state;
   logic [41:0]     capacity;

   assign csd_state = '{v2: v2_ff, size_count: csd_size_ff, block_len: csd_bl_ff,
                        multiplier: csd_mult_ff};

   sdreg_capacity u_capacity (
      .csd            (csd_state),
      .capacity_bytes (capacity)
   );

   assign req_ch.ready = !out_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign timeout_dec  = timeout_left_ff - 15'd1;

   always_comb begin
      card_is_v2_in    = card_is_v2_ff;
      start_timeout_in = start_timeout_ff;
      in_block_in      = in_block_ff;
      byte_idx_in      = byte_idx_ff;
      timeout_left_in  = timeout_left_ff;
      cid_hi_in        = cid_hi_ff;
      cid_lo_in        = cid_lo_ff;
      csd_size_in      = csd_size_ff;
      csd_bl_in        = csd_bl_ff;
      csd_mult_in      = csd_mult_ff;
      csd_misc_in      = csd_misc_ff;
      kind_in          = kind_ff;
      v2_in            = v2_ff;
      load             = 1'b0;
      out_in           = '0;

      if (accept) begin
         if (!in_block_ff) begin
            timeout_left_in = timeout_dec;
            if (timeout_dec == 15'd0) begin
               load             = 1'b1;
               out_in.status    = 1'b1;
               out_in.which_reg = req_ch.reg_kind;
               timeout_left_in  = start_timeout_ff;
            end else if (req_ch.rx_byte == START_TOKEN) begin
               in_block_in = 1'b1;
               byte_idx_in = 5'd0;
               kind_in     = req_ch.reg_kind;
               v2_in       = card_is_v2_ff;
               cid_hi_in   = '0;
               cid_lo_in   = '0;
               csd_size_in = '0;
               csd_bl_in   = '0;
               csd_mult_in = '0;
               csd_misc_in = '0;
            end
         end else begin
            if (!kind_ff) begin
               if (byte_idx_ff < CID_HI_BYTES) begin
                  cid_hi_in = {cid_hi_ff[55:0], req_ch.rx_byte};
               end else if (byte_idx_ff < CID_END_IDX) begin
                  cid_lo_in = {cid_lo_ff[47:0], req_ch.rx_byte};
               end
            end else if (byte_idx_ff == CSD_IDX_MISC) begin
               csd_misc_in = req_ch.rx_byte[6:2];
            end else if (v2_ff) begin
               if (byte_idx_ff == CSD_IDX_SIZE_B) begin
                  csd_size_in = {16'd0, req_ch.rx_byte[5:0]};
               end else if (byte_idx_ff == CSD_IDX_SIZE_C || byte_idx_ff == CSD_IDX_MULT_A) begin
                  csd_size_in = {csd_size_ff[13:0], req_ch.rx_byte};
               end
            end else begin
               if (byte_idx_ff == CSD_IDX_BL_LEN) begin
                  csd_bl_in = req_ch.rx_byte[3:0];
               end else if (byte_idx_ff == CSD_IDX_SIZE_A) begin
                  csd_size_in = {12'd0, req_ch.rx_byte[1:0], 8'd0};
               end else if (byte_idx_ff == CSD_IDX_SIZE_B) begin
                  csd_size_in = {csd_size_ff[19:0] | {12'd0, req_ch.rx_byte}, 2'b00};
               end else if (byte_idx_ff == CSD_IDX_SIZE_C) begin
                  csd_size_in = csd_size_ff | {20'd0, req_ch.rx_byte[7:6]};
               end else if (byte_idx_ff == CSD_IDX_MULT_A) begin
                  csd_mult_in = {req_ch.rx_byte[1:0], 1'b0};
               end else if (byte_idx_ff == CSD_IDX_MULT_B) begin
                  csd_mult_in = csd_mult_ff | {2'b00, req_ch.rx_byte[7]};
               end
            end

            if (byte_idx_ff == LAST_BYTE_IDX) begin
               load             = 1'b1;
               out_in.which_reg = kind_ff;
               if (!kind_ff) begin
                  out_in.manufacturer  = cid_hi_ff[63:56];
                  out_in.oem_id        = cid_hi_ff[55:40];
                  out_in.product_name  = cid_hi_ff[39:0];
                  out_in.revision      = cid_lo_ff[55:48];
                  out_in.serial_number = cid_lo_ff[47:16];
                  out_in.mfg_date      = cid_lo_ff[15:0];
               end else begin
                  out_in.capacity_bytes = capacity;
                  out_in.csd_flags      = csd_misc_ff[4:2];
                  out_in.file_format    = csd_misc_ff[1:0];
               end
               in_block_in     = 1'b0;
               byte_idx_in     = 5'd0;
               timeout_left_in = start_timeout_ff;
            end else begin
               byte_idx_in = byte_idx_ff + 5'd1;
            end
         end
      end

      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_CARD_IS_V2: begin
               card_is_v2_in = csr_wdata[0];
            end
            CSR_START_TIMEOUT: begin
               start_timeout_in = csr_wdata;
               timeout_left_in  = csr_wdata;
            end
            default: begin
               card_is_v2_in = card_is_v2_ff;
            end
         endcase
      end

      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         card_is_v2_ff    <= 1'b0;
         start_timeout_ff <= TIMEOUT_RESET;
         in_block_ff      <= 1'b0;
         byte_idx_ff      <= 5'd0;
         timeout_left_ff  <= TIMEOUT_RESET;
         kind_ff          <= 1'b0;
         v2_ff            <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         card_is_v2_ff    <= card_is_v2_in;
         start_timeout_ff <= start_timeout_in;
         in_block_ff      <= in_block_in;
         byte_idx_ff      <= byte_idx_in;
         timeout_left_ff  <= timeout_left_in;
         kind_ff          <= kind_in;
         v2_ff            <= v2_in;
         out_valid_ff     <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cid_hi_ff   <= cid_hi_in;
      cid_lo_ff   <= cid_lo_in;
      csd_size_ff <= csd_size_in;
      csd_bl_ff   <= csd_bl_in;
      csd_mult_ff <= csd_mult_in;
      csd_misc_ff <= csd_misc_in;
      if (load) begin
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.status         = out_ff.status;
   assign rsp_ch.which_reg      = out_ff.which_reg;
   assign rsp_ch.manufacturer   = out_ff.manufacturer;
   assign rsp_ch.oem_id         = out_ff.oem_id;
   assign rsp_ch.product_name   = out_ff.product_name;
   assign rsp_ch.revision       = out_ff.revision;
   assign rsp_ch.serial_number  = out_ff.serial_number;
   assign rsp_ch.mfg_date       = out_ff.mfg_date;
   assign rsp_ch.capacity_bytes = out_ff.capacity_bytes;
   assign rsp_ch.csd_flags      = out_ff.csd_flags;
   assign rsp_ch.file_format    = out_ff.file_format;

   // The byte counter only runs inside a register block.
   a_idle_index: assert property (@(posedge clock) disable iff (reset)
      !in_block_ff |-> byte_idx_ff == 5'd0)
      else $error("byte index moved while hunting for the start token");

   a_last_byte_result: assert property (@(posedge clock) disable iff (reset)
      accept && in_block_ff && byte_idx_ff == LAST_BYTE_IDX |=> out_valid_ff && !in_block_ff)
      else $error("last byte of a block did not produce a result");

   a_timeout_empty: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.status |-> out_ff.capacity_bytes == '0 &&
         out_ff.manufacturer == '0 && out_ff.serial_number == '0)
      else $error("timeout result carries decoded fields");

   a_cid_no_csd: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.which_reg |-> out_ff.capacity_bytes == '0 &&
         out_ff.csd_flags == '0 && out_ff.file_format == '0)
      else $error("CID result carries CSD fields");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for the SD card CID/CSD register decoder: a byte-level predictor,
// directed and random byte streams with random idling on both channels.
// Depends on sdreg_pkg, sdreg_req_if, sdreg_rsp_if and the decoder top level.
module tb_top;
   import sdreg_pkg::*;

   localparam realtime CLK_PERIOD     = 12ns;
   localparam int      LIMIT_CYCLES   = 600000;
   localparam int      IDLE_MAX       = 17;
   localparam int      LONG_HOLD      = 400;
   localparam int      SETTLE_CYCLES  = 4;
   localparam int      RANDOM_BYTES   = 400;
   localparam int      BLOCK_BYTES    = 18;
   localparam int      SECTOR_BYTES   = 512;
   localparam logic [7:0] TOKEN_BYTE  = 8'hFE;
   localparam logic    KIND_CID       = 1'b0;
   localparam logic    KIND_CSD       = 1'b1;

   typedef enum {FILL_ZERO, FILL_ONES, FILL_RANDOM} block_fill_type;

   logic          clock;
   logic          reset;
   logic          csr_wr_en;
   csr_index_type csr_index;
   logic [14:0]   csr_wdata;

   sdreg_req_if req_ch();
   sdreg_rsp_if rsp_ch();

   sd_cid_csd_register_decoder_top dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   // Predictor state and its copy of the configuration.
   logic        cfg_v2            = 1'b0;
   logic [14:0] cfg_timeout       = 15'd20000;
   logic        in_register_block = 1'b0;
   logic [4:0]  block_pos         = '0;
   logic [14:0] hunt_left         = 15'd20000;
   logic [63:0] cid_upper         = '0;
   logic [55:0] cid_lower         = '0;
   logic [21:0] csd_c_size        = '0;
   logic [3:0]  csd_read_bl_len   = '0;
   logic [2:0]  csd_c_size_mult   = '0;
   logic [4:0]  csd_byte14_bits   = '0;
   logic        latched_kind      = 1'b0;
   logic        latched_v2        = 1'b0;

   rsp_payload_type pending_decodes[$];

   int unsigned bytes_sent      = 0;
   int unsigned results_checked = 0;
   int unsigned cid_results     = 0;
   int unsigned csd_results     = 0;
   int unsigned timeout_results = 0;
   int unsigned mismatches      = 0;
   int unsigned send_gap_max    = IDLE_MAX;
   int unsigned rcv_gap_max     = IDLE_MAX;
   int unsigned hold_cycles     = 0;

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   function automatic void restart_hunt();
      in_register_block = 1'b0;
      block_pos = '0;
      hunt_left = cfg_timeout;
   endfunction

   task automatic predict_decode(input logic [7:0] b, input logic k);
      rsp_payload_type r;
      int              sh;
      logic [31:0]     cap32;
      r = '0;
      if (!in_register_block) begin
         hunt_left = hunt_left - 15'd1;
         if (hunt_left == 15'd0) begin
            r.status = 1'b1;
            r.which_reg = k;
            pending_decodes.push_back(r);
            restart_hunt();
         end else if (b == TOKEN_BYTE) begin
            in_register_block = 1'b1;
            block_pos = '0;
            latched_kind = k;
            latched_v2 = cfg_v2;
            cid_upper = '0;
            cid_lower = '0;
            csd_c_size = '0;
            csd_read_bl_len = '0;
            csd_c_size_mult = '0;
            csd_byte14_bits = '0;
         end
         return;
      end

      if (latched_kind == KIND_CID) begin
         if (block_pos < 5'd8) begin
            cid_upper = {cid_upper[55:0], b};
         end else if (block_pos < 5'd15) begin
            cid_lower = {cid_lower[47:0], b};
         end
      end else if (block_pos == 5'd14) begin
         csd_byte14_bits = b[6:2];
      end else if (latched_v2) begin
         if (block_pos == 5'd7) begin
            csd_c_size = {16'd0, b[5:0]};
         end else if (block_pos == 5'd8 || block_pos == 5'd9) begin
            csd_c_size = {csd_c_size[13:0], b};
         end
      end else begin
         case (block_pos)
            5'd5: csd_read_bl_len = b[3:0];
            5'd6: csd_c_size = {12'd0, b[1:0], 8'd0};
            5'd7: csd_c_size = (csd_c_size | {14'd0, b}) << 2;
            5'd8: csd_c_size = csd_c_size | {20'd0, b[7:6]};
            5'd9: csd_c_size_mult = {b[1:0], 1'b0};
            5'd10: csd_c_size_mult = csd_c_size_mult | {2'd0, b[7]};
            default: ;
         endcase
      end

      if (block_pos != 5'(BLOCK_BYTES - 1)) begin
         block_pos = block_pos + 5'd1;
         return;
      end

      r.which_reg = latched_kind;
      if (latched_kind == KIND_CID) begin
         r.manufacturer  = cid_upper[63:56];
         r.oem_id        = cid_upper[55:40];
         r.product_name  = cid_upper[39:0];
         r.revision      = cid_lower[55:48];
         r.serial_number = cid_lower[47:16];
         r.mfg_date      = cid_lower[15:0];
      end else begin
         if (latched_v2) begin
            r.capacity_bytes = (42'(csd_c_size) + 42'd1) * 42'(SECTOR_BYTES * 1024);
         end else begin
            // The version 1 capacity is formed in 32 bits, so large cards wrap.
            sh = int'(csd_c_size_mult) + int'(csd_read_bl_len) + 2;
            cap32 = (32'(csd_c_size[11:0]) + 32'd1) << sh;
            r.capacity_bytes = 42'(cap32);
         end
         r.csd_flags   = csd_byte14_bits[4:2];
         r.file_format = csd_byte14_bits[1:0];
      end
      pending_decodes.push_back(r);
      restart_hunt();
   endtask

   task automatic send_byte(input logic [7:0] b, input logic k);
      int unsigned gap;
      gap = (send_gap_max > 0) ? $urandom_range(0, send_gap_max) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.rx_byte  <= b;
      req_ch.reg_kind <= k;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      predict_decode(b, k);
      bytes_sent++;
   endtask

   task automatic send_block(input logic kind, input int lead_bytes,
                             input block_fill_type fill, input bit mix_kind);
      logic [7:0] b;
      repeat (lead_bytes) begin
         b = 8'($urandom_range(0, 255));
         if (b == TOKEN_BYTE || $urandom_range(0, 1) == 0) begin
            b = 8'hFF;
         end
         send_byte(b, mix_kind ? 1'($urandom_range(0, 1)) : kind);
      end
      send_byte(TOKEN_BYTE, kind);
      repeat (BLOCK_BYTES) begin
         case (fill)
            FILL_ZERO: b = 8'h00;
            FILL_ONES: b = 8'hFF;
            default: b = 8'($urandom_range(0, 255));
         endcase
         send_byte(b, mix_kind ? 1'($urandom_range(0, 1)) : kind);
      end
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (pending_decodes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [14:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_CARD_IS_V2) begin
         cfg_v2 = value[0];
      end else begin
         cfg_timeout = value;
         hunt_left = value;
      end
      @(posedge clock);
   endtask

   // Result side: a random stall after each item, plus an optional long hold.
   initial begin
      int unsigned stall;
      stall = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            stall = (rcv_gap_max > 0) ? $urandom_range(0, rcv_gap_max) : 0;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ch.ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("Mismatch in %s of result %0d at %0t: expected 0x%0h, got 0x%0h",
                     name, results_checked, $realtime, want, got);
         end
      end
   endfunction

   task automatic check_result();
      rsp_payload_type want;
      rsp_payload_type got;
      got = {rsp_ch.status, rsp_ch.which_reg, rsp_ch.manufacturer, rsp_ch.oem_id,
             rsp_ch.product_name, rsp_ch.revision, rsp_ch.serial_number,
             rsp_ch.mfg_date, rsp_ch.capacity_bytes, rsp_ch.csd_flags,
             rsp_ch.file_format};
      if (pending_decodes.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("Result at %0t with no decode pending: 0x%0h", $realtime, got);
         end
         return;
      end
      want = pending_decodes.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("which_reg", want.which_reg, got.which_reg);
      compare_field("manufacturer", want.manufacturer, got.manufacturer);
      compare_field("oem_id", want.oem_id, got.oem_id);
      compare_field("product_name", want.product_name, got.product_name);
      compare_field("revision", want.revision, got.revision);
      compare_field("serial_number", want.serial_number, got.serial_number);
      compare_field("mfg_date", want.mfg_date, got.mfg_date);
      compare_field("capacity_bytes", want.capacity_bytes, got.capacity_bytes);
      compare_field("csd_flags", want.csd_flags, got.csd_flags);
      compare_field("file_format", want.file_format, got.file_format);
      results_checked++;
      if (want.status) begin
         timeout_results++;
      end else if (want.which_reg == KIND_CID) begin
         cid_results++;
      end else begin
         csd_results++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         check_result();
      end
   end

   // These first blocks run with the reset configuration.
   task automatic test_cid_decode();
      send_block(KIND_CID, 0, FILL_ZERO, 1'b0);
      send_block(KIND_CID, 3, FILL_ONES, 1'b0);
      send_block(KIND_CID, 1, FILL_RANDOM, 1'b0);
      settle();
   endtask

   task automatic test_csd_v1_capacity();
      send_block(KIND_CSD, 0, FILL_ZERO, 1'b0);
      send_block(KIND_CSD, 0, FILL_ONES, 1'b0);
      send_block(KIND_CSD, 2, FILL_RANDOM, 1'b0);
      send_block(KIND_CSD, 0, FILL_RANDOM, 1'b0);
      settle();
   endtask

   task automatic test_csd_v2_capacity();
      write_csr(CSR_CARD_IS_V2, 15'd1);
      send_block(KIND_CSD, 0, FILL_ZERO, 1'b0);
      send_block(KIND_CSD, 0, FILL_ONES, 1'b0);
      send_block(KIND_CSD, 1, FILL_RANDOM, 1'b0);
      send_block(KIND_CSD, 0, FILL_RANDOM, 1'b0);
      settle();
   endtask

   // The register kind and card version are taken from the token byte only.
   task automatic test_register_latching();
      send_block(KIND_CID, 2, FILL_RANDOM, 1'b1);
      send_block(KIND_CSD, 0, FILL_RANDOM, 1'b1);
      settle();
      write_csr(CSR_CARD_IS_V2, 15'd1);
      send_byte(TOKEN_BYTE, KIND_CSD);
      repeat (9) send_byte(8'($urandom_range(0, 255)), KIND_CID);
      settle();
      write_csr(CSR_CARD_IS_V2, 15'd0);
      repeat (9) send_byte(8'($urandom_range(0, 255)), KIND_CID);
      settle();
   endtask

   task automatic test_token_timeout();
      write_csr(CSR_START_TIMEOUT, 15'd1);
      send_byte(TOKEN_BYTE, KIND_CSD);
      send_byte(8'h00, KIND_CID);
      send_byte(8'hFF, KIND_CSD);
      settle();
      // A token on the last allowed byte still times out.
      write_csr(CSR_START_TIMEOUT, 15'd2);
      send_byte(8'hFF, KIND_CID);
      send_byte(TOKEN_BYTE, KIND_CSD);
      send_block(KIND_CID, 0, FILL_RANDOM, 1'b0);
      settle();
      write_csr(CSR_START_TIMEOUT, 15'd5);
      send_block(KIND_CSD, 4, FILL_ZERO, 1'b0);
      send_block(KIND_CID, 0, FILL_RANDOM, 1'b0);
      send_block(KIND_CSD, 3, FILL_RANDOM, 1'b0);
      settle();
   endtask

   // A zero start timeout wraps to 32768 bytes, so a short lead still finds the token.
   task automatic test_timeout_extremes();
      write_csr(CSR_START_TIMEOUT, 15'd0);
      send_block(KIND_CID, 6, FILL_RANDOM, 1'b0);
      settle();
      write_csr(CSR_START_TIMEOUT, 15'd32767);
      send_block(KIND_CSD, 6, FILL_RANDOM, 1'b0);
      settle();
   endtask

   task automatic test_result_backpressure();
      write_csr(CSR_START_TIMEOUT, 15'd20000);
      send_gap_max = 0;
      hold_cycles = LONG_HOLD;
      repeat (4) send_block(1'($urandom_range(0, 1)), 0, FILL_RANDOM, 1'b0);
      send_gap_max = IDLE_MAX;
      settle();
   endtask

   task automatic test_random_traffic();
      int unsigned first_byte;
      logic [14:0] limit;
      first_byte = bytes_sent;
      while (bytes_sent - first_byte < RANDOM_BYTES) begin
         settle();
         write_csr(CSR_CARD_IS_V2, 15'($urandom_range(0, 1)));
         case ($urandom_range(0, 7))
            0: limit = 15'($urandom_range(1, 3));
            1, 2, 3: limit = 15'($urandom_range(8, 40));
            4: limit = 15'd20000;
            5: limit = 15'd32767;
            default: limit = 15'($urandom_range(41, 32767));
         endcase
         write_csr(CSR_START_TIMEOUT, limit);
         send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
         rcv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
         repeat ($urandom_range(3, 8)) begin
            if ($urandom_range(0, 6) == 0) begin
               repeat ($urandom_range(1, 30)) begin
                  send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
               end
            end else begin
               send_block(1'($urandom_range(0, 1)), $urandom_range(0, 12), FILL_RANDOM,
                          $urandom_range(0, 9) == 0);
            end
         end
      end
      send_gap_max = IDLE_MAX;
      rcv_gap_max = IDLE_MAX;
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_CARD_IS_V2;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.rx_byte = '0;
      req_ch.reg_kind = 1'b0;
      restart_hunt();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_cid_decode();
      test_csd_v1_capacity();
      test_csd_v2_capacity();
      test_register_latching();
      test_token_timeout();
      test_timeout_extremes();
      test_result_backpressure();
      test_random_traffic();
      settle();

      $display("Sent %0d bytes; checked %0d results: %0d CID, %0d CSD, %0d token timeouts.",
               bytes_sent, results_checked, cid_results, csd_results, timeout_results);
      $display("Exercised both CSD capacity rules, start timeouts from 0 to 32767, %0s",
               "register latching and a long result stall.");
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches in total.", mismatches);
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #(CLK_PERIOD * LIMIT_CYCLES);
      $display("Run timed out with %0d results outstanding.", pending_decodes.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== sd_cid_csd_register_decoder_top.f =====
rtl/sdreg_pkg.sv
rtl/sdreg_req_if.sv
rtl/sdreg_rsp_if.sv
rtl/sdreg_capacity.sv
rtl/sd_cid_csd_register_decoder_top.sv
sim/tb_top.sv
